// ----- rtl/bfgl_pkg.sv -----
package bfgl_pkg;

    localparam int MAX_BLOCKS_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SIZE_W     = 13;
    localparam int CODE_W     = 16;
    localparam int OFFSET_W   = 32;
    localparam int ENTRY_W    = 2 * CODE_W;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_BYTE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd3;

    localparam logic [7:0] GLYPH_WIDTH_RST  = 8'd8;
    localparam logic [7:0] GLYPH_HEIGHT_RST = 8'd16;
    localparam logic       DOUBLE_BYTE_RST  = 1'b0;
    localparam logic [7:0] BLOCK_COUNT_RST  = 8'd0;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [OFFSET_W-1:0] SBCS_BASE  = 32'd17;
    localparam logic [OFFSET_W-1:0] DBCS_BASE  = 32'd18;
    localparam logic [CODE_W:0]     SBCS_CODES = 17'h100;

    localparam logic [8:0] PITCH_ROUND = 9'd7;
    localparam int         PITCH_SHIFT = 3;

    typedef struct packed {
        logic [7:0]        glyph_width;
        logic [7:0]        glyph_height;
        logic              double_byte;
        logic [7:0]        block_count;
        logic [SIZE_W-1:0] glyph_size;
    } cfg_t;

endpackage

// ----- rtl/bfgl_cfg_regs.sv -----
module bfgl_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bfgl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfgl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output bfgl_pkg::cfg_t                   cfg
);

    logic [7:0] glyph_width_reg;
    logic [7:0] glyph_height_reg;
    logic       double_byte_reg;
    logic [7:0] block_count_reg;
    logic [5:0] pitch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_width_reg  <= bfgl_pkg::GLYPH_WIDTH_RST;
            glyph_height_reg <= bfgl_pkg::GLYPH_HEIGHT_RST;
            double_byte_reg  <= bfgl_pkg::DOUBLE_BYTE_RST;
            block_count_reg  <= bfgl_pkg::BLOCK_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bfgl_pkg::REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_wdata;
                bfgl_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata;
                bfgl_pkg::REG_DOUBLE_BYTE:  double_byte_reg  <= cfg_wdata[0];
                bfgl_pkg::REG_BLOCK_COUNT:  block_count_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign pitch = 6'(({1'b0, glyph_width_reg} + bfgl_pkg::PITCH_ROUND)
                      >> bfgl_pkg::PITCH_SHIFT);

    assign cfg.glyph_width  = glyph_width_reg;
    assign cfg.glyph_height = glyph_height_reg;
    assign cfg.double_byte  = double_byte_reg;
    assign cfg.block_count  = block_count_reg;
    assign cfg.glyph_size   = bfgl_pkg::SIZE_W'(pitch) * bfgl_pkg::SIZE_W'(glyph_height_reg);

endmodule

// ----- rtl/bfgl_block_table.sv -----
module bfgl_block_table #(
    parameter int DEPTH = bfgl_pkg::MAX_BLOCKS_DEF,
    parameter int AW    = 8
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [bfgl_pkg::ENTRY_W-1:0]      wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [bfgl_pkg::ENTRY_W-1:0]      rd_data
);

    logic [bfgl_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [bfgl_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bitmap_font_glyph_locator_unit.sv -----
// Sequence: a table write is taken in the idle state and gives no result. A single-byte
// lookup goes from idle to the multiply state and then to done; a double-byte lookup walks
// the table until block k hits and then multiplies, and a miss walks block_count blocks,
// capped at MAX_BLOCKS, then goes to done. The result is registered from done.
// Throughput: one item at a time, taken only when idle; the walk reads one block per cycle.
// Reset: aresetn is synchronous and active low; control and config registers reset, the
// datapath and block table are not cleared; the table holds undefined data until written.
module bitmap_font_glyph_locator_unit #(
    parameter int MAX_BLOCKS = bfgl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [bfgl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfgl_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [7:0]                        s_block_index,
    input  logic [15:0]                       s_range_start,
    input  logic [15:0]                       s_range_end,
    input  logic [15:0]                       s_code,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic [31:0]                       m_glyph_offset,
    output logic [12:0]                       m_glyph_bytes
);

    localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_MUL, ST_DONE} state_t;

    bfgl_pkg::cfg_t cfg;

    state_t       state_reg, state_next;
    logic         m_valid_reg, m_valid_next;
    logic         cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic         found_reg, found_next;
    logic [15:0]  code_reg, code_next;
    logic [31:0]  before_reg, before_next;
    logic [31:0]  term_reg, term_next;
    logic [31:0]  prod_reg, prod_next;
    logic         m_found_reg, m_found_next;
    logic [31:0]  m_offset_reg, m_offset_next;
    logic [12:0]  m_bytes_reg, m_bytes_next;

    logic         s_xfer;
    logic         tbl_we;
    logic         tbl_re;
    logic [bfgl_pkg::ENTRY_W-1:0] tbl_rd_data;
    logic [15:0]  blk_lo, blk_hi;
    logic         blk_hit;
    logic [CNT_W-1:0] walk_len;
    logic [31:0]  base;

    bfgl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bfgl_block_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (s_block_index[AW-1:0]),
        .wr_data ({s_range_start, s_range_end}),
        .rd_en   (tbl_re),
        .rd_addr (issue_cnt_reg[AW-1:0]),
        .rd_data (tbl_rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign tbl_we  = s_xfer && (s_kind == bfgl_pkg::KIND_WRITE)
                     && ({1'b0, s_block_index} < 9'(MAX_BLOCKS));

    assign walk_len = ({1'b0, cfg.block_count} < 9'(MAX_BLOCKS))
                      ? CNT_W'(cfg.block_count) : CNT_W'(MAX_BLOCKS);
    assign tbl_re   = (state_reg == ST_WALK) && (issue_cnt_reg < walk_len);

    assign blk_lo  = tbl_rd_data[31:16];
    assign blk_hi  = tbl_rd_data[15:0];
    assign blk_hit = (code_reg >= blk_lo) && (code_reg <= blk_hi);

    assign base = cfg.double_byte
                  ? bfgl_pkg::DBCS_BASE + {22'd0, cfg.block_count, 2'b00}
                  : bfgl_pkg::SBCS_BASE;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmp_valid_next = 1'b0;
        issue_cnt_next = issue_cnt_reg;
        found_next     = found_reg;
        code_next      = code_reg;
        before_next    = before_reg;
        term_next      = term_reg;
        prod_next      = prod_reg;
        m_found_next   = m_found_reg;
        m_offset_next  = m_offset_reg;
        m_bytes_next   = m_bytes_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_kind == bfgl_pkg::KIND_LOOKUP) begin
                    code_next      = s_code;
                    before_next    = '0;
                    issue_cnt_next = '0;
                    if (cfg.double_byte) begin
                        state_next = ST_WALK;
                    end else begin
                        term_next  = 32'(s_code);
                        found_next = ({1'b0, s_code} < bfgl_pkg::SBCS_CODES);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_WALK: begin
                if (tbl_re) begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                if (cmp_valid_reg) begin
                    if (blk_hit) begin
                        found_next     = 1'b1;
                        term_next      = before_reg + 32'(code_reg) - 32'(blk_lo);
                        cmp_valid_next = 1'b0;
                        state_next     = ST_MUL;
                    end else begin
                        before_next = before_reg + 32'(blk_hi) - 32'(blk_lo) + 32'd1;
                    end
                end else if (!tbl_re) begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_MUL: begin
                prod_next  = term_reg * 32'(cfg.glyph_size);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = found_reg;
                    m_offset_next = found_reg ? base + prod_reg : '0;
                    m_bytes_next  = cfg.glyph_size;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        issue_cnt_reg <= issue_cnt_next;
        found_reg     <= found_next;
        code_reg      <= code_next;
        before_reg    <= before_next;
        term_reg      <= term_next;
        prod_reg      <= prod_next;
        m_found_reg   <= m_found_next;
        m_offset_reg  <= m_offset_next;
        m_bytes_reg   <= m_bytes_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_glyph_offset = m_offset_reg;
    assign m_glyph_bytes  = m_bytes_reg;

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_we |-> !tbl_re && !cmp_valid_reg)
        else $error("Block table written during a walk.");

    a_cmp_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> state_reg == ST_WALK)
        else $error("Table compare outside the walk.");

    a_mul_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |=> state_reg == ST_DONE)
        else $error("Offset multiply did not advance to result.");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_glyph_offset == 32'd0)
        else $error("Not-found result carries a nonzero offset.");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && (!m_valid_reg || m_ready) |=> m_valid && s_ready)
        else $error("Finished lookup did not produce its result.");

endmodule
